FILE: hdl/conv2d_threshold_binarize_top_defines.svh
// assertion macros for the top level rtl
`ifndef CONV2D_THRESHOLD_BINARIZE_TOP_DEFINES_SVH
`define CONV2D_THRESHOLD_BINARIZE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define C2TB_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define C2TB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/c2tb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package c2tb_pkg;

  // defaults for the top level parameters
  localparam int C2TB_MAX_KERNEL     = 9;
  localparam int C2TB_MAX_WIDTH      = 512;
  localparam int C2TB_COEF_FRAC_BITS = 8;

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int COEF_W    = 16;
  localparam int CIDX_W    = 7;
  localparam int POS_W     = 9;
  localparam int KS_W      = 4;
  localparam int DIM_W     = 10;
  localparam int CFG_IDX_W = 2;

  // accumulation widths: product, row of up to 9, sum of up to 9 rows
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ROW_W  = PROD_W + 4;
  localparam int SUM_W  = ROW_W + 4;

  localparam logic [PIX_W-1:0] LEVEL_ON  = 8'd255;
  localparam logic [PIX_W-1:0] LEVEL_OFF = 8'd0;

  localparam logic [KS_W-1:0]  KSIZE_RST = 4'd3;
  localparam logic [DIM_W-1:0] DIM_RST   = 10'd512;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KSIZE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // per-pixel result bookkeeping carried down the pipe
  typedef struct packed {
    logic             interior;
    logic             border;
    logic             bor_on;
    logic [POS_W-1:0] int_row;
    logic [POS_W-1:0] int_col;
    logic [POS_W-1:0] bor_row;
    logic [POS_W-1:0] bor_col;
  } meta_t;

  // stage enables and coefficient write for the mac datapath
  typedef struct packed {
    logic                     prod_en;
    logic                     row_en;
    logic                     sum_en;
    logic                     coef_we;
    logic [CIDX_W-1:0]        coef_idx;
    logic signed [COEF_W-1:0] coef_val;
  } mac_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/c2tb_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input items: coefficient loads and pixels
interface c2tb_in_if import c2tb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [CIDX_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic [PIX_W-1:0]         pixel_value;

  modport source (output valid, opcode, coef_index, coef_value, pixel_value, input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, pixel_value, output ready);
endinterface

// result items
interface c2tb_out_if import c2tb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] out_row;
  logic [POS_W-1:0] out_col;
  logic [PIX_W-1:0] level;
  logic             last_of_run;

  modport source (output valid, out_row, out_col, level, last_of_run, input ready);
  modport sink   (input valid, out_row, out_col, level, last_of_run, output ready);
endinterface

// register writes
interface c2tb_cfg_if import c2tb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/c2tb_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none
module c2tb_linebuf import c2tb_pkg::*; #(
  parameter int MaxKernel = C2TB_MAX_KERNEL,
  parameter int MaxWidth  = C2TB_MAX_WIDTH
) (
  input  logic                                      clk_i,
  input  logic                                      acc_i,
  input  logic [$clog2(MaxWidth)-1:0]               addr_i,
  input  logic [((MaxKernel > 2) ? $clog2(MaxKernel-1) : 1)-1:0] wr_slot_i,
  input  logic [PIX_W-1:0]                          wr_pix_i,
  input  logic                                      shift_en_i,
  input  logic [((MaxKernel > 2) ? $clog2(MaxKernel-1) : 1)-1:0] sh_slot_i,
  input  logic [PIX_W-1:0]                          sh_pix_i,
  output logic [PIX_W-1:0]                          win_o [MaxKernel][MaxKernel]
);

  localparam int Lines = MaxKernel - 1;
  localparam int SlotW = (MaxKernel > 2) ? $clog2(MaxKernel-1) : 1;

  // one word per column, one byte lane per stored line
  logic [Lines*PIX_W-1:0] mem_q [MaxWidth];
  logic [Lines*PIX_W-1:0] rd_q;
  logic [PIX_W-1:0]       win_q [MaxKernel][MaxKernel];
  logic [SlotW:0]         lane  [Lines];
  logic [PIX_W-1:0]       col_in [Lines];

  // read-first column access, new pixel written into its row's lane
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_q <= mem_q[addr_i];
      for (int l = 0; l < Lines; l++) begin
        if (wr_slot_i == SlotW'(l)) begin
          mem_q[addr_i][l*PIX_W +: PIX_W] <= wr_pix_i;
        end
      end
    end
  end

  // rotate lanes so that window row i gets the line i rows below the oldest
  always_comb begin
    for (int i = 0; i < Lines; i++) begin
      lane[i] = {1'b0, sh_slot_i} + (SlotW+1)'(i);
      if (lane[i] >= (SlotW+1)'(Lines)) begin
        lane[i] = lane[i] - (SlotW+1)'(Lines);
      end
      col_in[i] = '0;
      for (int l = 0; l < Lines; l++) begin
        if (lane[i] == (SlotW+1)'(l)) begin
          col_in[i] = rd_q[l*PIX_W +: PIX_W];
        end
      end
    end
  end

  // window shifts left once per pixel transfer
  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      for (int i = 0; i < MaxKernel; i++) begin
        for (int j = 0; j < MaxKernel - 1; j++) begin
          win_q[i][j] <= win_q[i][j+1];
        end
      end
      for (int i = 0; i < Lines; i++) begin
        win_q[i][MaxKernel-1] <= col_in[i];
      end
      win_q[MaxKernel-1][MaxKernel-1] <= sh_pix_i;
    end
  end

  assign win_o = win_q;

endmodule
`default_nettype wire

FILE: hdl/c2tb_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module c2tb_mac import c2tb_pkg::*; #(
  parameter int MaxKernel    = C2TB_MAX_KERNEL,
  parameter int CoefFracBits = C2TB_COEF_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mac_ctrl_t        ctrl_i,
  input  logic [KS_W-1:0]  h_i,
  input  logic [PIX_W-1:0] win_i [MaxKernel][MaxKernel],
  output logic             hit_o
);

  localparam int Taps = MaxKernel * MaxKernel;
  localparam int TapW = $clog2(Taps);
  localparam int HMax = (MaxKernel - 1) / 2;
  localparam logic signed [SUM_W-1:0] Thresh = SUM_W'(64'sd1 << (CoefFracBits - 1));

  logic signed [COEF_W-1:0] coef_q [Taps];
  logic signed [COEF_W-1:0] csel   [MaxKernel][MaxKernel];
  logic                     tap_on [MaxKernel][MaxKernel];
  logic signed [PROD_W-1:0] prod_q [MaxKernel][MaxKernel];
  logic signed [ROW_W-1:0]  row_acc [MaxKernel];
  logic signed [ROW_W-1:0]  rows_q  [MaxKernel];
  logic signed [SUM_W-1:0]  sum_acc;
  logic signed [SUM_W-1:0]  sum_q;

  // coefficient store, written when a load leaves the second stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < Taps; t++) begin
        coef_q[t] <= '0;
      end
    end else if (ctrl_i.coef_we && (ctrl_i.coef_idx < CIDX_W'(Taps))) begin
      coef_q[ctrl_i.coef_idx[TapW-1:0]] <= ctrl_i.coef_val;
    end
  end

  // place the kernel in the lower right corner of the window
  always_comb begin
    for (int a = 0; a < MaxKernel; a++) begin
      for (int b = 0; b < MaxKernel; b++) begin
        csel[a][b]   = '0;
        tap_on[a][b] = 1'b0;
      end
    end
    for (int hh = 0; hh <= HMax; hh++) begin
      if (h_i == KS_W'(hh)) begin
        for (int i = 0; i <= 2*hh; i++) begin
          for (int j = 0; j <= 2*hh; j++) begin
            csel[MaxKernel-1-2*hh+i][MaxKernel-1-2*hh+j]   = coef_q[i*MaxKernel+j];
            tap_on[MaxKernel-1-2*hh+i][MaxKernel-1-2*hh+j] = 1'b1;
          end
        end
      end
    end
  end

  // tap products, taps outside the kernel give zero whatever the window holds
  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      for (int a = 0; a < MaxKernel; a++) begin
        for (int b = 0; b < MaxKernel; b++) begin
          prod_q[a][b] <= tap_on[a][b] ?
                          PROD_W'($signed({1'b0, win_i[a][b]})) * PROD_W'(csel[a][b]) : '0;
        end
      end
    end
  end

  // row sums and total
  always_comb begin
    sum_acc = '0;
    for (int a = 0; a < MaxKernel; a++) begin
      row_acc[a] = '0;
      for (int b = 0; b < MaxKernel; b++) begin
        row_acc[a] = row_acc[a] + ROW_W'(prod_q[a][b]);
      end
      sum_acc = sum_acc + SUM_W'(rows_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.row_en) begin
      rows_q <= row_acc;
    end
    if (ctrl_i.sum_en) begin
      sum_q <= sum_acc;
    end
  end

  // at least one half
  assign hit_o = (sum_q >= Thresh);

endmodule
`default_nettype wire

FILE: hdl/conv2d_threshold_binarize_top.sv
// pipeline: a pixel moves through registers s1, m0, m1, m2, m3 and then the output pair
// throughput: one item per cycle unless the output is held; a pixel with both an interior
//   and a border result holds the output register until both leave by the single result port
// reset: control, counters, config (K=3, 512x512) and coefficients are cleared at once;
//   the line memory and the window are not cleared and there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module conv2d_threshold_binarize_top import c2tb_pkg::*; #(
  parameter int MaxKernel    = C2TB_MAX_KERNEL,
  parameter int MaxWidth     = C2TB_MAX_WIDTH,
  parameter int CoefFracBits = C2TB_COEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2tb_in_if.sink     in_i,
  c2tb_out_if.source  out_o,
  c2tb_cfg_if.sink    cfg_i
);

`include "conv2d_threshold_binarize_top_defines.svh"

  localparam int Lines = MaxKernel - 1;
  localparam int SlotW = (MaxKernel > 2) ? $clog2(MaxKernel-1) : 1;
  localparam int AddrW = $clog2(MaxWidth);
  localparam logic [KS_W-1:0]  KMax = KS_W'(MaxKernel);
  localparam logic [DIM_W-1:0] WMax = (MaxWidth > 1023) ? {DIM_W{1'b1}} : DIM_W'(MaxWidth);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Lines - 1);

  // config registers
  logic [KS_W-1:0]  ks_q;
  logic [DIM_W-1:0] wd_q, ht_q;

  // effective sizes
  logic [KS_W-1:0]  k_sat, k_eff, h_cur;
  logic [DIM_W-1:0] w_eff, h_eff, hw, two_h;

  // position counters
  logic [DIM_W-1:0] col_q, col_d, row_q, row_d, c_cur, r_cur;
  logic [SlotW-1:0] slot_q, slot_d, s_cur;
  logic [DIM_W:0]   r_ext, c_nx, r_nx;
  meta_t            meta_new;

  // pipeline
  logic                     in_acc, pix_acc;
  logic                     v1_q, v2_q, v3_q, v4_q, v5_q;
  logic                     rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;
  op_e                      s1_op_q, m0_op_q;
  logic [CIDX_W-1:0]        s1_cidx_q, m0_cidx_q;
  logic signed [COEF_W-1:0] s1_cval_q, m0_cval_q;
  logic [PIX_W-1:0]         s1_pix_q;
  logic [SlotW-1:0]         s1_slot_q;
  meta_t                    s1_meta_q, m0_meta_q, m1_meta_q, m2_meta_q, m3_meta_q;
  logic [PIX_W-1:0]         win [MaxKernel][MaxKernel];
  mac_ctrl_t                mac_ctrl;
  logic                     hit;

  // output pair
  logic             o0_q, o1_q, lvl0_q, lvl1_q;
  logic [POS_W-1:0] row0_q, col0_q, row1_q, col1_q;

  // config write port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q <= KSIZE_RST;
      wd_q <= DIM_RST;
      ht_q <= DIM_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_KSIZE:  ks_q <= cfg_i.data[KS_W-1:0];
        CFG_WIDTH:  wd_q <= cfg_i.data;
        CFG_HEIGHT: ht_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // kernel size saturated and made odd, width saturated, zero width or height taken as 1
  always_comb begin
    k_sat = (ks_q > KMax) ? KMax : ks_q;
    if (!k_sat[0]) begin
      k_eff = (k_sat == '0) ? KS_W'(1) : k_sat - KS_W'(1);
    end else begin
      k_eff = k_sat;
    end
    h_cur = k_eff >> 1;
    hw    = DIM_W'(h_cur);
    two_h = DIM_W'({h_cur, 1'b0});
    w_eff = (wd_q > WMax) ? WMax : wd_q;
    if (w_eff == '0) begin
      w_eff = DIM_W'(1);
    end
    h_eff = (ht_q == '0) ? DIM_W'(1) : ht_q;
  end

  // position of this pixel and of the next one
  always_comb begin
    c_cur = col_q;
    r_ext = {1'b0, row_q};
    s_cur = slot_q;
    if (col_q >= w_eff) begin
      c_cur = '0;
      r_ext = r_ext + (DIM_W+1)'(1);
      s_cur = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
    end
    if (r_ext >= {1'b0, h_eff}) begin
      r_ext = '0;
      s_cur = '0;
    end
    r_cur = r_ext[DIM_W-1:0];

    c_nx   = {1'b0, c_cur} + (DIM_W+1)'(1);
    r_nx   = {1'b0, r_cur} + (DIM_W+1)'(1);
    col_d  = c_nx[DIM_W-1:0];
    row_d  = r_cur;
    slot_d = s_cur;
    if (c_nx >= {1'b0, w_eff}) begin
      col_d  = '0;
      row_d  = r_nx[DIM_W-1:0];
      slot_d = (s_cur == LastSlot) ? '0 : s_cur + SlotW'(1);
      if (r_nx >= {1'b0, h_eff}) begin
        row_d  = '0;
        slot_d = '0;
      end
    end

    meta_new.interior = (r_cur >= two_h) && (c_cur >= two_h);
    meta_new.border   = (r_cur < hw) || (c_cur < hw) ||
                        (({1'b0, r_cur} + {1'b0, hw}) >= {1'b0, h_eff}) ||
                        (({1'b0, c_cur} + {1'b0, hw}) >= {1'b0, w_eff});
    meta_new.bor_on   = (in_i.pixel_value != '0);
    meta_new.int_row  = POS_W'(r_cur - hw);
    meta_new.int_col  = POS_W'(c_cur - hw);
    meta_new.bor_row  = r_cur[POS_W-1:0];
    meta_new.bor_col  = c_cur[POS_W-1:0];
  end

  assign in_acc  = in_i.valid && in_i.ready;
  assign pix_acc = in_acc && (op_e'(in_i.opcode) == OP_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (pix_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // ready chain: a stage takes a new item when empty or when it moves on
  assign out_rdy = (!o0_q && !o1_q) || ((o0_q ^ o1_q) && out_o.ready);
  assign rdy5    = !v5_q || out_rdy;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q && (m0_op_q == OP_PIXEL);
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_op_q   <= op_e'(in_i.opcode);
      s1_cidx_q <= in_i.coef_index;
      s1_cval_q <= in_i.coef_value;
      s1_pix_q  <= in_i.pixel_value;
      s1_slot_q <= s_cur;
      s1_meta_q <= meta_new;
    end
    if (rdy2) begin
      m0_op_q   <= s1_op_q;
      m0_cidx_q <= s1_cidx_q;
      m0_cval_q <= s1_cval_q;
      m0_meta_q <= s1_meta_q;
    end
    if (rdy3) m1_meta_q <= m0_meta_q;
    if (rdy4) m2_meta_q <= m1_meta_q;
    if (rdy5) m3_meta_q <= m2_meta_q;
  end

  // line memory and window
  c2tb_linebuf #(
    .MaxKernel (MaxKernel),
    .MaxWidth  (MaxWidth)
  ) u_linebuf (
    .clk_i      (clk_i),
    .acc_i      (pix_acc),
    .addr_i     (AddrW'(c_cur)),
    .wr_slot_i  (s_cur),
    .wr_pix_i   (in_i.pixel_value),
    .shift_en_i (v1_q && rdy2 && (s1_op_q == OP_PIXEL)),
    .sh_slot_i  (s1_slot_q),
    .sh_pix_i   (s1_pix_q),
    .win_o      (win)
  );

  // mac datapath control
  always_comb begin
    mac_ctrl.prod_en  = v2_q && rdy3;
    mac_ctrl.row_en   = v3_q && rdy4;
    mac_ctrl.sum_en   = v4_q && rdy5;
    mac_ctrl.coef_we  = v2_q && rdy3 && (m0_op_q == OP_LOAD);
    mac_ctrl.coef_idx = m0_cidx_q;
    mac_ctrl.coef_val = m0_cval_q;
  end

  c2tb_mac #(
    .MaxKernel    (MaxKernel),
    .CoefFracBits (CoefFracBits)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .h_i    (h_cur),
    .win_i  (win),
    .hit_o  (hit)
  );

  // output pair: interior result first, then border result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o0_q <= 1'b0;
      o1_q <= 1'b0;
    end else if (v5_q && out_rdy) begin
      o0_q <= m3_meta_q.interior;
      o1_q <= m3_meta_q.border;
    end else if (out_o.valid && out_o.ready) begin
      if (o0_q) begin
        o0_q <= 1'b0;
      end else begin
        o1_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v5_q && out_rdy) begin
      row0_q <= m3_meta_q.int_row;
      col0_q <= m3_meta_q.int_col;
      lvl0_q <= hit;
      row1_q <= m3_meta_q.bor_row;
      col1_q <= m3_meta_q.bor_col;
      lvl1_q <= m3_meta_q.bor_on;
    end
  end

  assign out_o.valid       = o0_q || o1_q;
  assign out_o.out_row     = o0_q ? row0_q : row1_q;
  assign out_o.out_col     = o0_q ? col0_q : col1_q;
  assign out_o.level       = (o0_q ? lvl0_q : lvl1_q) ? LEVEL_ON : LEVEL_OFF;
  assign out_o.last_of_run = !(o0_q && o1_q);

  // checks
  `C2TB_ASSERT_NOW(a_stall_only_when_full, !in_i.ready, v1_q, "input stalled with empty head stage")
  `C2TB_ASSERT_NEXT(a_col_in_frame, pix_acc, col_q < $past(w_eff), "column beyond width")
  `C2TB_ASSERT_NEXT(a_row_in_frame, pix_acc, row_q < $past(h_eff), "row beyond height")
  `C2TB_ASSERT_NOW(a_pair_blocks, o0_q && o1_q, !out_rdy, "output pair overwritten")

endmodule
`default_nettype wire

FILE: dv/conv2d_threshold_binarize_top_tb.sv
`timescale 1ns / 1ps
module conv2d_threshold_binarize_top_tb;
  import c2tb_pkg::*;

  localparam int KMAX  = C2TB_MAX_KERNEL;
  localparam int WMAX  = C2TB_MAX_WIDTH;
  localparam int NTAPS = KMAX * KMAX;

  typedef struct {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] level;
    logic             last;
  } bin_result_t;

  // tracks the image stream and holds the binarized pixels still owed by the block
  class conv_scoreboard;
    logic signed [COEF_W-1:0] taps [NTAPS];
    logic [PIX_W-1:0]         recent_rows [KMAX][WMAX];
    int unsigned              ksize_reg, width_reg, height_reg;
    int                       row_pos, col_pos;
    bin_result_t              owed_q [$];
    int                       errors, checked, pixels, loads;

    function new();
      foreach (taps[i]) taps[i] = '0;
      foreach (recent_rows[i, j]) recent_rows[i][j] = '0;
      ksize_reg  = KSIZE_RST;
      width_reg  = DIM_RST;
      height_reg = DIM_RST;
      row_pos    = 0;
      col_pos    = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_KSIZE:  ksize_reg = data[KS_W-1:0];
        CFG_WIDTH:  width_reg = data;
        CFG_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function void note_input(op_e op, logic [CIDX_W-1:0] idx,
                             logic signed [COEF_W-1:0] val, logic [PIX_W-1:0] pix);
      int          w, hgt, k, h, n;
      longint      acc;
      bin_result_t res;
      if (op == OP_LOAD) begin
        loads++;
        if (idx < NTAPS) taps[idx] = val;
        return;
      end
      pixels++;
      w   = (width_reg > WMAX) ? WMAX : ((width_reg == 0) ? 1 : width_reg);
      hgt = (height_reg == 0) ? 1 : height_reg;
      k   = (ksize_reg > KMAX) ? KMAX : ksize_reg;
      if (k % 2 == 0) k = (k == 0) ? 1 : k - 1;
      h   = k / 2;
      // wrap counters left past the frame
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= hgt) row_pos = 0;
      recent_rows[row_pos % KMAX][col_pos] = pix;
      n = owed_q.size();
      // interior result for the pixel centered h rows and columns back
      if (row_pos >= 2 * h && col_pos >= 2 * h) begin
        acc = 0;
        for (int i = 0; i < k; i++)
          for (int j = 0; j < k; j++)
            acc += longint'(taps[i * KMAX + j]) *
                   longint'(recent_rows[(row_pos - 2 * h + i) % KMAX][col_pos - 2 * h + j]);
        res.row   = POS_W'(row_pos - h);
        res.col   = POS_W'(col_pos - h);
        res.level = (acc >= (longint'(1) << (C2TB_COEF_FRAC_BITS - 1))) ? LEVEL_ON : LEVEL_OFF;
        res.last  = 1'b0;
        owed_q.push_back(res);
      end
      // own border result
      if (row_pos < h || col_pos < h || row_pos + h >= hgt || col_pos + h >= w) begin
        res.row   = POS_W'(row_pos);
        res.col   = POS_W'(col_pos);
        res.level = (pix != 0) ? LEVEL_ON : LEVEL_OFF;
        res.last  = 1'b0;
        owed_q.push_back(res);
      end
      if (owed_q.size() > n) owed_q[owed_q.size() - 1].last = 1'b1;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= hgt) row_pos = 0;
      end
    endfunction

    function void check_result(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                               logic [PIX_W-1:0] level, logic last);
      bin_result_t want;
      checked++;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result row %0d col %0d level %0d last %0b",
                   $realtime, row, col, level, last);
        return;
      end
      want = owed_q.pop_front();
      if (row !== want.row || col !== want.col || level !== want.level ||
          last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp row %0d col %0d level %0d last %0b, got %0d %0d %0d %0b",
                   $realtime, want.row, want.col, want.level, want.last,
                   row, col, level, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  c2tb_in_if  in_if ();
  c2tb_out_if out_if ();
  c2tb_cfg_if cfg_if ();

  conv_scoreboard sb = new();
  int src_idle = 0;
  int snk_stall = 0;
  int idle_mode = 0;
  int rand_pixels = 0;
  int phases = 0;

  conv2d_threshold_binarize_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // result side: check each transfer, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.out_row, out_if.out_col, out_if.level, out_if.last_of_run);
    out_if.ready <= ($urandom_range(99) >= snk_stall);
  end

  task automatic push_item(op_e op, logic [CIDX_W-1:0] idx,
                           logic signed [COEF_W-1:0] val, logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.coef_index  <= idx;
    in_if.coef_value  <= val;
    in_if.pixel_value <= pix;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(op, idx, val, pix);
  endtask

  task automatic load_tap(logic [CIDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
    push_item(OP_LOAD, idx, val, PIX_W'($urandom));
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] pix);
    push_item(OP_PIXEL, CIDX_W'($urandom), COEF_W'($urandom), pix);
  endtask

  // wait for every owed result, then let the pipe drain before a register write
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [DIM_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [COEF_W-1:0] rand_tap();
    if ($urandom_range(1)) return COEF_W'(int'($urandom_range(1024)) - 512);
    return COEF_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // one or more whole frames at the given settings, loads mixed in now and then
  task automatic run_phase(logic [DIM_W-1:0] ks, logic [DIM_W-1:0] w,
                           logic [DIM_W-1:0] h, int frames, bit count_rand);
    int npix;
    drain();
    write_reg(CFG_KSIZE, ks);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    idle_mode = (idle_mode + 1) % 4;
    case (idle_mode)
      0: begin src_idle = 0;  snk_stall = 0;  end
      1: begin src_idle = 47; snk_stall = 0;  end
      2: begin src_idle = 0;  snk_stall = 47; end
      default: begin src_idle = 8; snk_stall = 8; end
    endcase
    phases++;
    npix = ((w > WMAX) ? WMAX : ((w == 0) ? 1 : w)) * ((h == 0) ? 1 : h) * frames;
    for (int p = 0; p < npix; p++) begin
      if ($urandom_range(19) == 0) load_tap(CIDX_W'($urandom), rand_tap());
      send_pixel(rand_pix());
      if (count_rand) rand_pixels++;
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_LOAD;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.pixel_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_KSIZE;
    cfg_if.data = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tap extremes, ignored indexes, a unit center tap
    load_tap(7'd0, 16'sh7fff);
    load_tap(7'd80, 16'sh8000);
    load_tap(7'd81, 16'sh7fff);
    load_tap(7'd127, 16'sh8000);
    load_tap(7'd10, 16'sd256);
    load_tap(7'd1, -16'sd128);
    drain();
    write_reg(cfg_idx_e'(2'd3), 10'h3ff);
    write_reg(CFG_KSIZE, 10'd3);
    write_reg(CFG_WIDTH, 10'd9);
    write_reg(CFG_HEIGHT, 10'd9);
    for (int p = 0; p < 81; p++)
      send_pixel((p % 3 == 0) ? 8'd0 : ((p % 3 == 1) ? 8'd255 : 8'd1));

    // kernel size and frame size extremes, out of range values
    run_phase(10'h3f9, 10'd9, 10'd9, 1, 0);     // K=9
    run_phase(10'd15, 10'd9, 10'd9, 1, 0);      // saturated size
    run_phase(10'd0, 10'd10, 10'd9, 1, 0);      // zero size used as 1
    run_phase(10'd8, 10'd9, 10'd10, 1, 0);      // even size lowered
    run_phase(10'd2, 10'd0, 10'd0, 6, 0);       // one-pixel frames
    run_phase(10'd3, 10'd0, 10'd0, 6, 0);

    // random frames with fresh random kernels
    while (rand_pixels < 100) begin
      drain();
      for (int t = 0; t < NTAPS; t++) load_tap(CIDX_W'(t), rand_tap());
      run_phase(DIM_W'({$urandom_range(63), 4'($urandom_range(15))}),
                DIM_W'($urandom_range(12, 9)), DIM_W'($urandom_range(10, 9)),
                1, 1);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d pixels and %0d coefficient loads over %0d register phases",
             sb.pixels, sb.loads, phases);
    $display("checked %0d binarized results, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout with %0d results still owed", sb.owed_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/c2tb_pkg.sv
hdl/c2tb_if.sv
hdl/c2tb_linebuf.sv
hdl/c2tb_mac.sv
hdl/conv2d_threshold_binarize_top.sv
dv/conv2d_threshold_binarize_top_tb.sv
